// ===== rtl/spq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants for the sorted priority queue
// Depth, field widths, operation and status codes, and the cell entry type.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEPTH   = 8;                    // range 2 .. 15
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int VALUE_W = 32;
  localparam int PRIO_W  = 8;
  localparam int MODE_W  = 2;
  localparam int STAT_W  = 2;
  localparam int FILL_W  = 4;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_PEEK   = 2'd2
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic        [PRIO_W-1:0]  prio;
  } entry_t;

  // Chain-wide command, given to every cell
  typedef struct packed {
    logic insert;   // place new entry, shift lower entries down
    logic remove;   // drop head, shift all entries up
  } chain_ctrl_t;

endpackage

// ===== rtl/spq_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_req_if: request channel of the sorted priority queue
// Valid/ready handshake carrying the operation, value and priority.
// ----------------------------------------------------------------------------
interface spq_req_if
  import spq_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [MODE_W-1:0]         mode;
  logic signed [VALUE_W-1:0] item_value;
  logic [PRIO_W-1:0]         item_priority;

  modport source (output valid, mode, item_value, item_priority, input ready);
  modport sink   (input valid, mode, item_value, item_priority, output ready);
endinterface

// ===== rtl/spq_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_rsp_if: response channel of the sorted priority queue
// Valid/ready handshake carrying status, head entry and fill count.
// ----------------------------------------------------------------------------
interface spq_rsp_if
  import spq_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [STAT_W-1:0]         status;
  logic signed [VALUE_W-1:0] head_value;
  logic [PRIO_W-1:0]         head_priority;
  logic [FILL_W-1:0]         fill_count;

  modport source (output valid, status, head_value, head_priority, fill_count,
                  input ready);
  modport sink   (input valid, status, head_value, head_priority, fill_count,
                  output ready);
endinterface

// ===== rtl/spq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted shift chain
// Keeps, takes the new entry, or takes a neighbor's entry each cycle.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
(
  input  logic        clk,
  input  chain_ctrl_t ctrl,
  input  entry_t      new_entry,
  input  entry_t      left_entry,   // slot above (toward head)
  input  entry_t      right_entry,  // slot below (toward tail)
  input  logic        left_keep,    // slot above stays put on insert
  input  logic        occupied,
  output logic        keep,
  output entry_t      entry
);

  // Stays put when occupied and it outranks or ties the new entry
  assign keep = occupied && (entry.prio >= new_entry.prio);

  always_ff @(posedge clk) begin
    if (ctrl.insert && !keep) begin
      entry <= left_keep ? new_entry : left_entry;
    end else if (ctrl.remove) begin
      entry <= right_entry;
    end
  end

endmodule

// ===== rtl/sorted_priority_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue: bounded priority queue on a sorted shift chain
// Inserts behind equal or higher priorities, removes or peeks the head.
// ----------------------------------------------------------------------------
//
//  channel | dir | payload                                        | handshake
//  --------+-----+------------------------------------------------+-----------
//  req     | in  | mode, item_value, item_priority                | valid/ready
//  rsp     | out | status, head_value, head_priority, fill_count  | valid/ready
//
//  One request per cycle while the response register is free or drained:
//  every cell compares its priority against the incoming one in parallel
//  and all cells shift at once. The response is registered and appears in the cycle after acceptance.
//  rst (synchronous) clears the fill count and the response valid; the
//  cells' contents are not reset and slots beyond the count are never read.
//  A stalled response holds in the output register; req.ready drops only
//  while that register is full and not being drained.
// ----------------------------------------------------------------------------
module sorted_priority_queue
  import spq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  spq_req_if.sink   req,
  spq_rsp_if.source rsp
);

  // Fill count (state of the whole chain)
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  // Chain wiring
  entry_t      cell_entry [DEPTH];
  logic        cell_keep  [DEPTH];
  entry_t      new_entry;
  chain_ctrl_t ctrl;

  // Response register
  logic                      out_valid;
  logic [STAT_W-1:0]         out_status;
  logic signed [VALUE_W-1:0] out_value;
  logic [PRIO_W-1:0]         out_prio;
  logic [FILL_W-1:0]         out_fill;

  logic              accept;
  logic              full;
  logic              empty;
  logic [STAT_W-1:0] status_next;
  entry_t            head_next;

  assign req.ready = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);

  assign new_entry.value = req.item_value;
  assign new_entry.prio  = req.item_priority;

  // Decode: refused inserts and empty removes leave the chain alone
  always_comb begin
    ctrl        = '0;
    count_next  = count;
    status_next = ST_OK;
    head_next   = '0;
    case (req.mode)
      MODE_INSERT: begin
        if (full) begin
          status_next = ST_OVERFLOW;
        end else begin
          ctrl.insert = accept;
          count_next  = count + CNT_W'(1);
        end
      end
      MODE_REMOVE: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          ctrl.remove = accept;
          count_next  = count - CNT_W'(1);
          head_next   = cell_entry[0];
        end
      end
      MODE_PEEK: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          head_next = cell_entry[0];
        end
      end
      default: begin
        // unused code: no change, plain ok response
      end
    endcase
  end

  // Cell row: slot 0 is the head
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_e;
    entry_t right_e;
    logic   left_k;

    if (i == 0) begin : g_first
      assign left_e = new_entry;
      assign left_k = 1'b1;
    end else begin : g_mid_left
      assign left_e = cell_entry[i-1];
      assign left_k = cell_keep[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_e = cell_entry[i];
    end else begin : g_mid_right
      assign right_e = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .new_entry   (new_entry),
      .left_entry  (left_e),
      .right_entry (right_e),
      .left_keep   (left_k),
      .occupied    (count > CNT_W'(i)),
      .keep        (cell_keep[i]),
      .entry       (cell_entry[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status <= status_next;
      out_value  <= head_next.value;
      out_prio   <= head_next.prio;
      out_fill   <= FILL_W'(count_next);
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.head_value    = out_value;
  assign rsp.head_priority = out_prio;
  assign rsp.fill_count    = out_fill;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("fill count beyond depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && req.mode == MODE_INSERT && !full) |=> count == $past(count) + CNT_W'(1))
    else $error("accepted insert did not grow the queue");

  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    (count >= CNT_W'(2)) |-> cell_entry[1].prio <= cell_entry[0].prio)
    else $error("head outranked by second slot");

  a_empty_rsp: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == ST_EMPTY) |-> rsp.fill_count == '0)
    else $error("empty status with nonzero fill count");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the sorted priority queue
// Streams directed and random insert / remove / peek requests through the
// request channel, predicts every response with an in-bench sorted store,
// and checks each response field by field under varying handshake pressure.
// ----------------------------------------------------------------------------
module tb;
  import spq_pkg::*;

  // One request as it travels on the request channel
  typedef struct packed {
    logic [MODE_W-1:0]         mode;
    logic signed [VALUE_W-1:0] value;
    logic [PRIO_W-1:0]         prio;
  } op_t;

  // One response as it comes back on the response channel
  typedef struct packed {
    logic [STAT_W-1:0]         status;
    logic signed [VALUE_W-1:0] value;
    logic [PRIO_W-1:0]         prio;
    logic [FILL_W-1:0]         fill;
  } reply_t;

  // Mode code the block does not define; it must be ignored
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  localparam int N_RANDOM     = 1580;     // random requests that do real work
  localparam int DRAIN_CYCLES = 16;       // settle time after the last response
  localparam int CLK_HALF     = 2;        // 4 ns period

  logic clk;
  logic rst;

  spq_req_if req_ch ();
  spq_rsp_if rsp_ch ();

  sorted_priority_queue DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  op_t         req_backlog[$];    // requests still to be offered
  reply_t      due_replies[$];    // predicted responses, oldest first
  op_t         on_bus;            // request currently offered on req_ch
  int unsigned total_reqs;
  int unsigned loaded;            // requests placed on the bus so far
  int unsigned accepted;          // requests taken by the block
  int unsigned checked;           // responses compared
  int unsigned errors;
  logic [1:0]  phase;             // handshake pressure phase, 0 .. 3

  // Pressure phases: sender idles 31 / receiver 78, then swapped, then none
  int snd_idle_pct;
  int rcv_idle_pct;
  assign snd_idle_pct = (phase == 2'd0) ? 31 : (phase == 2'd1) ? 78 : 0;
  assign rcv_idle_pct = (phase == 2'd0) ? 78 : (phase == 2'd1) ? 31 : 0;

  // --------------------------------------------------------------------------
  // Predictor: a sorted store, head in slot 0, highest priority first
  // --------------------------------------------------------------------------
  entry_t      held[DEPTH];
  int unsigned held_n;
  int unsigned n_ins, n_rem, n_peek, n_spare, n_ovf, n_empty;

  // Apply one request to the store and return the response it must cause
  function automatic reply_t serve_request(op_t op);
    reply_t      r;
    int unsigned pos;
    r        = '0;
    r.status = ST_OK;
    case (op.mode)
      MODE_INSERT: begin
        if (held_n >= DEPTH) begin
          // full: store untouched, head fields stay zero
          r.status = ST_OVERFLOW;
          n_ovf++;
        end else begin
          // go behind every entry of equal or higher priority, so ties
          // leave in arrival order
          pos = 0;
          while (pos < held_n && held[pos].prio >= op.prio) pos++;
          for (int k = held_n; k > pos; k--) held[k] = held[k-1];
          held[pos].value = op.value;
          held[pos].prio  = op.prio;
          held_n++;
          n_ins++;
        end
      end
      MODE_REMOVE, MODE_PEEK: begin
        if (held_n == 0) begin
          r.status = ST_EMPTY;
          n_empty++;
        end else begin
          r.value = held[0].value;
          r.prio  = held[0].prio;
          if (op.mode == MODE_REMOVE) begin
            for (int k = 1; k < held_n; k++) held[k-1] = held[k];
            held_n--;
            n_rem++;
          end else begin
            n_peek++;
          end
        end
      end
      default: begin
        // spare mode: nothing changes, plain ok with the current count
        n_spare++;
      end
    endcase
    r.fill = FILL_W'(held_n);
    return r;
  endfunction

  task automatic push_op(input logic [MODE_W-1:0] m, input logic [VALUE_W-1:0] v,
                         input logic [PRIO_W-1:0] p);
    op_t o;
    o.mode  = m;
    o.value = v;
    o.prio  = p;
    req_backlog.push_back(o);
  endtask

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Driver: offers the backlog one request at a time. A request stays on the
  // bus untouched until the block takes it; only an idle bus may go quiet.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid         <= 1'b0;
      req_ch.mode          <= MODE_INSERT;
      req_ch.item_value    <= '0;
      req_ch.item_priority <= '0;
      phase                <= 2'd0;
    end else begin
      // a request taken at this edge updates the predictor right away
      if (req_ch.valid && req_ch.ready) begin
        due_replies.push_back(serve_request(on_bus));
        accepted++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (req_backlog.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
          on_bus               = req_backlog.pop_front();
          req_ch.valid         <= 1'b1;
          req_ch.mode          <= on_bus.mode;
          req_ch.item_value    <= on_bus.value;
          req_ch.item_priority <= on_bus.prio;
          loaded++;
          phase <= 2'((loaded * 3) / total_reqs);
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: takes responses under random back-pressure and checks each one
  // against the oldest prediction.
  // --------------------------------------------------------------------------
  reply_t got;
  reply_t want;

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.status = rsp_ch.status;
        got.value  = rsp_ch.head_value;
        got.prio   = rsp_ch.head_priority;
        got.fill   = rsp_ch.fill_count;
        checked++;
        if (due_replies.size() == 0) begin
          errors++;
          $display("%0t: response with nothing pending: status=%0d value=%0d prio=%0d fill=%0d",
                   $time, got.status, got.value, got.prio, got.fill);
        end else begin
          want = due_replies.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: mismatch: expected status=%0d value=%0d prio=%0d fill=%0d",
                     $time, want.status, want.value, want.prio, want.fill);
            $display("%0t:           actual   status=%0d value=%0d prio=%0d fill=%0d",
                     $time, got.status, got.value, got.prio, got.fill);
          end
        end
      end
      rsp_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    int unsigned       real_cnt;
    int unsigned       burst;
    int unsigned       style;
    int unsigned       roll;
    int unsigned       sel;
    logic [MODE_W-1:0]  m;
    logic [VALUE_W-1:0] v;
    logic [PRIO_W-1:0]  p;

    rst                  = 1'b1;
    loaded               = 0;
    accepted             = 0;
    checked              = 0;
    errors               = 0;
    held_n               = 0;
    n_ins = 0; n_rem = 0; n_peek = 0; n_spare = 0; n_ovf = 0; n_empty = 0;

    // Directed part: empty-queue remove/peek, spare mode, value and priority
    // extremes, a run of equal priorities, overflow, and a full drain.
    push_op(MODE_PEEK,   32'h0, 8'h0);
    push_op(MODE_REMOVE, 32'hFFFF_FFFF, 8'hFF);
    push_op(MODE_SPARE,  32'h1234_5678, 8'h5A);
    push_op(MODE_INSERT, 32'h8000_0000, 8'd0);
    push_op(MODE_INSERT, 32'h7FFF_FFFF, 8'd255);
    push_op(MODE_INSERT, 32'd11, 8'd128);
    push_op(MODE_INSERT, 32'd22, 8'd128);
    push_op(MODE_INSERT, 32'd33, 8'd128);
    push_op(MODE_INSERT, 32'hFFFF_FFFF, 8'd0);
    push_op(MODE_INSERT, 32'h0, 8'd255);
    push_op(MODE_INSERT, 32'hDEAD_BEEF, 8'd127);
    push_op(MODE_INSERT, 32'h5555_5555, 8'd200);   // overflow: queue is full
    push_op(MODE_PEEK,   32'h0, 8'h0);
    push_op(MODE_SPARE,  32'hAAAA_AAAA, 8'hA5);
    repeat (DEPTH) push_op(MODE_REMOVE, 32'h0, 8'h0);
    push_op(MODE_REMOVE, 32'h0, 8'h0);
    push_op(MODE_PEEK,   32'h0, 8'h0);

    // Random part: bursts that lean toward filling, draining or balance so
    // the queue moves across its whole range; priorities often collide.
    real_cnt = 0;
    while (real_cnt < N_RANDOM) begin
      burst = $urandom_range(4, 24);
      style = $urandom_range(0, 2);
      repeat (burst) begin
        roll = $urandom_range(0, 99);
        case (style)
          0:       m = (roll < 65) ? MODE_INSERT : (roll < 85) ? MODE_REMOVE : MODE_PEEK;
          1:       m = (roll < 30) ? MODE_INSERT : (roll < 80) ? MODE_REMOVE : MODE_PEEK;
          default: m = (roll < 45) ? MODE_INSERT : (roll < 80) ? MODE_REMOVE : MODE_PEEK;
        endcase
        if ($urandom_range(0, 99) < 3) m = MODE_SPARE;
        sel = $urandom_range(0, 9);
        case (sel)
          0:       v = 32'h8000_0000;
          1:       v = 32'h7FFF_FFFF;
          2:       v = $urandom_range(0, 15);
          default: v = $urandom;
        endcase
        sel = $urandom_range(0, 9);
        case (sel)
          0, 1, 2, 3: p = PRIO_W'($urandom_range(0, 3));
          4:          p = 8'd0;
          5:          p = 8'd255;
          default:    p = PRIO_W'($urandom_range(0, 255));
        endcase
        push_op(m, v, p);
        if (m != MODE_SPARE) real_cnt++;
      end
    end
    total_reqs = req_backlog.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (accepted < total_reqs || due_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests: %0d inserts, %0d removes, %0d peeks, %0d spare-mode",
             total_reqs, n_ins, n_rem, n_peek, n_spare);
    $display("  %0d overflows, %0d empty hits, %0d responses checked, %0d errors",
             n_ovf, n_empty, checked, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/spq_pkg.sv
rtl/spq_req_if.sv
rtl/spq_rsp_if.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
tb/tb.sv
